// ----- src/wcmp_pkg.sv -----
// Shared types, constants and command/status groups for the weighted cluster
// minimum p-value block. No dependencies.
package wcmp_pkg;

    localparam int SUM_WIDTH = 48;
    localparam longint unsigned MAX_ITEMS = 64'd16777216;
    localparam int POS_W = $clog2(MAX_ITEMS);
    localparam int IDX_W = 24;
    localparam int DIVD_W = 32 + SUM_WIDTH;
    localparam int QBITS = 33;
    localparam int HIGH_W = DIVD_W - QBITS;
    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_ORDER = 1'b1;

    typedef struct packed {
        logic [31:0]        p_value;
        logic signed [31:0] cluster_id;
        logic [31:0]        weight;
        logic               end_of_input;
    } item_t;

    typedef struct packed {
        logic [31:0]      adjusted_p;
        logic [IDX_W-1:0] best_index;
        logic             status;
        logic             run_last;
    } result_t;

    typedef enum logic [1:0] {
        MUL_CROSS_A,
        MUL_CROSS_B,
        MUL_T_LO,
        MUL_T_HI
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     dvd_load;
        logic     dvd_add_hi;
        logic     div_start;
        logic     update;
        logic     start_cl;
        logic     close;
        logic     set_err;
        logic     clr_state;
        logic     out_load;
        logic     out_err;
        logic     run_last;
    } cmd_t;

    typedef struct packed {
        logic err_seen;
        logic open;
        logic id_lt;
        logic id_eq;
        logic last;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

// ----- src/wcmp_divider.sv -----
// Restoring divider, one quotient bit a cycle, saturating to 1.0 in Q1.31.
// Depends on wcmp_pkg.
module wcmp_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [wcmp_pkg::DIVD_W-1:0] dividend,
    input  logic [31:0]               divisor,
    output logic                      done,
    output logic [31:0]               quotient
);
    import wcmp_pkg::*;

    localparam int CNT_W = $clog2(QBITS + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      rem_reg, rem_next;
    logic [QBITS-1:0] low_reg, low_next;
    logic [QBITS-1:0] q_reg, q_next;
    logic             sat_reg, sat_next;
    logic [31:0]      div_reg, div_next;

    logic [HIGH_W-1:0] high;
    logic [32:0]       trial;
    logic [32:0]       diff;
    logic              ge;

    assign high  = dividend[DIVD_W-1:QBITS];
    assign trial = {rem_reg, low_reg[QBITS-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign ge    = trial >= {1'b0, div_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        q_next     = q_reg;
        sat_next   = sat_reg;
        div_next   = div_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = CNT_W'(QBITS);
            rem_next   = high[31:0];
            low_next   = dividend[QBITS-1:0];
            q_next     = '0;
            sat_next   = high >= HIGH_W'(divisor);
            div_next   = divisor;
        end
        else if (busy_reg)
        begin
            rem_next   = ge ? diff[31:0] : trial[31:0];
            low_next   = {low_reg[QBITS-2:0], 1'b0};
            q_next     = {q_reg[QBITS-2:0], ge};
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
        sat_reg <= sat_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = (sat_reg || (q_reg > QBITS'(ONE_Q31))) ? ONE_Q31 : q_reg[31:0];

endmodule

// ----- src/wcmp_datapath.sv -----
// Datapath: item and cluster registers, shared 32x32 multiplier, dividend
// build-up, divider and result register. Depends on wcmp_pkg, wcmp_divider.
module wcmp_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  wcmp_pkg::cmd_t    cmd,
    output wcmp_pkg::stat_t   stat,
    input  wcmp_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output wcmp_pkg::result_t result
);
    import wcmp_pkg::*;

    logic                     open_reg, err_reg, out_valid_reg;
    logic [POS_W-1:0]         pos_reg;
    item_t                    item_reg;
    logic [POS_W-1:0]         item_pos_reg;
    logic signed [31:0]       cur_id_reg;
    logic [31:0]              best_p_reg, best_w_reg;
    logic [POS_W-1:0]         best_pos_reg;
    logic [SUM_WIDTH-1:0]     wt_reg;
    logic [63:0]              prod_reg, cross_reg;
    logic [DIVD_W-1:0]        dvd_reg;
    result_t                  out_reg;

    logic [63:0]              wt_ext;
    logic [31:0]              mul_a, mul_b;
    logic [SUM_WIDTH:0]       sum;
    logic                     less;
    logic                     div_done;
    logic [31:0]              quotient;
    logic [POS_W-1:0]         pos_inc;
    logic [63:0]              item_pos_ext, best_pos_ext;

    assign wt_ext       = 64'(wt_reg);
    assign sum          = {1'b0, wt_reg} + (SUM_WIDTH + 1)'(item_reg.weight);
    assign less         = cross_reg < prod_reg;
    assign pos_inc      = (pos_reg == POS_W'(MAX_ITEMS - 1)) ? '0 : pos_reg + POS_W'(1);
    assign item_pos_ext = 64'(item_pos_reg);
    assign best_pos_ext = 64'(best_pos_reg);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_CROSS_A:
            begin
                mul_a = item_reg.p_value;
                mul_b = best_w_reg;
            end
            MUL_CROSS_B:
            begin
                mul_a = best_p_reg;
                mul_b = item_reg.weight;
            end
            MUL_T_LO:
            begin
                mul_a = best_p_reg;
                mul_b = wt_ext[31:0];
            end
            default:
            begin
                mul_a = best_p_reg;
                mul_b = wt_ext[63:32];
            end
        endcase
    end

    wcmp_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd_reg),
        .divisor  (best_w_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= 1'b0;
            err_reg       <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                pos_reg <= pos_inc;
            if (cmd.start_cl)
                open_reg <= 1'b1;
            if (cmd.close)
                open_reg <= 1'b0;
            if (cmd.set_err)
                err_reg <= 1'b1;
            if (cmd.clr_state)
            begin
                open_reg <= 1'b0;
                err_reg  <= 1'b0;
                pos_reg  <= '0;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg     <= item;
            item_pos_reg <= pos_reg;
        end
        if (cmd.mul_en)
        begin
            prod_reg  <= 64'(mul_a) * 64'(mul_b);
            cross_reg <= prod_reg;
        end
        if (cmd.dvd_load)
            dvd_reg <= DIVD_W'(prod_reg);
        if (cmd.dvd_add_hi)
            dvd_reg <= dvd_reg + (DIVD_W'(prod_reg) << 32);
        if (cmd.update)
        begin
            wt_reg <= sum[SUM_WIDTH] ? '1 : sum[SUM_WIDTH-1:0];
            if (less)
            begin
                best_p_reg   <= item_reg.p_value;
                best_w_reg   <= item_reg.weight;
                best_pos_reg <= item_pos_reg;
            end
        end
        if (cmd.start_cl)
        begin
            cur_id_reg   <= item_reg.cluster_id;
            best_p_reg   <= item_reg.p_value;
            best_w_reg   <= item_reg.weight;
            best_pos_reg <= item_pos_reg;
            wt_reg       <= SUM_WIDTH'(item_reg.weight);
        end
        if (cmd.out_load)
        begin
            if (cmd.out_err)
            begin
                out_reg.adjusted_p <= '0;
                out_reg.best_index <= item_pos_ext[IDX_W-1:0];
                out_reg.status     <= STATUS_ORDER;
            end
            else
            begin
                out_reg.adjusted_p <= quotient;
                out_reg.best_index <= best_pos_ext[IDX_W-1:0];
                out_reg.status     <= STATUS_OK;
            end
            out_reg.run_last <= cmd.run_last;
        end
    end

    assign stat.err_seen = err_reg;
    assign stat.open     = open_reg;
    assign stat.id_lt    = item_reg.cluster_id < cur_id_reg;
    assign stat.id_eq    = item_reg.cluster_id == cur_id_reg;
    assign stat.last     = item_reg.end_of_input;
    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || result_ready;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ----- src/wcmp_controller.sv -----
// Sequencer for item intake, best-item update and cluster result generation.
// Depends on wcmp_pkg.
module wcmp_controller (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  wcmp_pkg::stat_t stat,
    output wcmp_pkg::cmd_t  cmd
);
    import wcmp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL_A,
        S_MUL_B,
        S_UPDATE,
        S_ADJ_LO,
        S_ADJ_HI,
        S_ADJ_SUM,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EMIT,
        S_ERR
    } state_t;

    state_t state_reg, state_next;
    logic   final_reg, final_next;

    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = MUL_CROSS_A;
        state_next  = state_reg;
        final_next  = final_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.err_seen)
                begin
                    cmd.clr_state = stat.last;
                    state_next    = S_IDLE;
                end
                else if (stat.open && stat.id_lt)
                    state_next = S_ERR;
                else if (stat.open && stat.id_eq)
                    state_next = S_MUL_A;
                else if (stat.open)
                begin
                    final_next = 1'b0;
                    state_next = S_ADJ_LO;
                end
                else
                begin
                    cmd.start_cl = 1'b1;
                    final_next   = 1'b1;
                    state_next   = stat.last ? S_ADJ_LO : S_IDLE;
                end
            end
            S_MUL_A:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_CROSS_A;
                state_next  = S_MUL_B;
            end
            S_MUL_B:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_CROSS_B;
                state_next  = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                final_next = 1'b1;
                state_next = stat.last ? S_ADJ_LO : S_IDLE;
            end
            S_ADJ_LO:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_T_LO;
                state_next  = S_ADJ_HI;
            end
            S_ADJ_HI:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_T_HI;
                cmd.dvd_load = 1'b1;
                state_next   = S_ADJ_SUM;
            end
            S_ADJ_SUM:
            begin
                cmd.dvd_add_hi = 1'b1;
                state_next     = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.run_last = final_reg || !stat.last;
                    if (final_reg)
                    begin
                        cmd.clr_state = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        cmd.start_cl = 1'b1;
                        final_next   = 1'b1;
                        state_next   = stat.last ? S_ADJ_LO : S_IDLE;
                    end
                end
            end
            S_ERR:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_err   = 1'b1;
                    cmd.run_last  = 1'b1;
                    cmd.close     = !stat.last;
                    cmd.clr_state = stat.last;
                    cmd.set_err   = !stat.last;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            final_reg <= final_next;
        end
    end

    assign item_ready = (state_reg == S_IDLE);

endmodule

// ----- src/weighted_cluster_min_pvalue.sv -----
// Top level of the weighted cluster minimum p-value block: controller plus
// datapath. Depends on wcmp_pkg, wcmp_controller, wcmp_datapath.
//
//   channel  handshake                  payload
//   -------  -------------------------  -----------------------------
//   item     item_valid / item_ready    item   (wcmp_pkg::item_t)
//   result   result_valid / result_ready result (wcmp_pkg::result_t)
//
// An item that stays in its cluster makes two passes through the shared
// 32x32 multiplier. A cluster result goes through ADJ_LO, ADJ_HI, ADJ_SUM and
// DIV_GO to form the 80-bit product and start the divider, then the bit-serial
// divider, then the output register load, plus any wait for it to free.
// An item closing one cluster and ending the stream makes two.
// Reset is asynchronous and active low; the block is ready straight after.
// A result waits in the output register; a stalled result channel holds back
// the next result and, while that result waits, intake of the next item.
module weighted_cluster_min_pvalue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  wcmp_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output wcmp_pkg::result_t result
);
    import wcmp_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    wcmp_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    wcmp_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for weighted_cluster_min_pvalue: directed, random and long-cluster item streams,
// each result checked against an in-bench prediction. Depends on wcmp_pkg and the block.
module testbench;
    import wcmp_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 100;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    weighted_cluster_min_pvalue dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // tracked cluster state
    logic                   cl_open;
    logic signed [31:0]     cur_id;
    logic [31:0]            best_p;
    logic [31:0]            best_w;
    logic [IDX_W-1:0]       best_pos;
    logic [SUM_WIDTH-1:0]   wsum;
    logic [IDX_W-1:0]       item_pos;
    logic                   err_flag;

    result_t expected_clusters[$];
    int      mismatches = 0;
    int      idle_cycles = 0;
    bit      calm = 1'b0;

    task automatic clear_tracker();
        cl_open  = 1'b0;
        cur_id   = '0;
        best_p   = '0;
        best_w   = '0;
        best_pos = '0;
        wsum     = '0;
        item_pos = '0;
        err_flag = 1'b0;
    endtask

    // floor(p * total / w), saturated to 1.0; zero weight gives 1.0
    function automatic logic [31:0] bonferroni_adjust(logic [31:0] p,
                                                      logic [SUM_WIDTH-1:0] total,
                                                      logic [31:0] w);
        logic [127:0] pw;
        logic [127:0] tw;
        logic [127:0] ww;
        logic [127:0] q;
        pw = 128'(p);
        tw = 128'(total);
        ww = 128'(w);
        if (w == 32'd0)
            return ONE_Q31;
        q = (pw * tw) / ww;
        if (q > {96'd0, ONE_Q31})
            return ONE_Q31;
        return q[31:0];
    endfunction

    function automatic result_t cluster_result();
        result_t r;
        r.adjusted_p = bonferroni_adjust(best_p, wsum, best_w);
        r.best_index = best_pos;
        r.status     = STATUS_OK;
        r.run_last   = 1'b0;
        return r;
    endfunction

    task automatic predict_cluster_outputs(input item_t it);
        result_t          outs[2];
        int               n;
        logic [IDX_W-1:0] here;
        logic [SUM_WIDTH:0] s;
        logic [63:0]      lhs;
        logic [63:0]      rhs;
        n = 0;
        here = item_pos;
        item_pos = item_pos + IDX_W'(1);
        if (err_flag)
        begin
            if (it.end_of_input)
                clear_tracker();
            return;
        end
        if (cl_open && $signed(it.cluster_id) < cur_id)
        begin
            outs[0].adjusted_p = '0;
            outs[0].best_index = here;
            outs[0].status     = STATUS_ORDER;
            outs[0].run_last   = 1'b1;
            expected_clusters.push_back(outs[0]);
            cl_open = 1'b0;
            if (it.end_of_input)
                clear_tracker();
            else
                err_flag = 1'b1;
            return;
        end
        if (cl_open && $signed(it.cluster_id) == cur_id)
        begin
            s = {1'b0, wsum} + (SUM_WIDTH + 1)'(it.weight);
            if (s[SUM_WIDTH])
                wsum = '1;
            else
                wsum = s[SUM_WIDTH-1:0];
            lhs = {32'd0, it.p_value} * {32'd0, best_w};
            rhs = {32'd0, best_p} * {32'd0, it.weight};
            if (lhs < rhs)
            begin
                best_p   = it.p_value;
                best_w   = it.weight;
                best_pos = here;
            end
        end
        else
        begin
            if (cl_open)
            begin
                outs[n] = cluster_result();
                n++;
            end
            cl_open  = 1'b1;
            cur_id   = it.cluster_id;
            best_p   = it.p_value;
            best_w   = it.weight;
            best_pos = here;
            wsum     = SUM_WIDTH'(it.weight);
        end
        if (it.end_of_input)
        begin
            outs[n] = cluster_result();
            n++;
            clear_tracker();
        end
        if (n > 0)
            outs[n-1].run_last = 1'b1;
        for (int k = 0; k < n; k++)
            expected_clusters.push_back(outs[k]);
    endtask

    task automatic send_item(input logic [31:0] p, input logic [31:0] id,
                             input logic [31:0] w, input logic eoi);
        item_t pkt;
        pkt.p_value      = p;
        pkt.cluster_id   = id;
        pkt.weight       = w;
        pkt.end_of_input = eoi;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        item       <= pkt;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        predict_cluster_outputs(pkt);
    endtask

    function automatic logic [31:0] rand_p();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return ONE_Q31;
            2: return $urandom;
            default: return $urandom_range(0, 32'h8000_0000) >> $urandom_range(0, 20);
        endcase
    endfunction

    function automatic logic [31:0] rand_w();
        case ($urandom_range(0, 19))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3, 4: return $urandom;
            default: return $urandom_range(32'h0000_4000, 32'h0004_0000);
        endcase
    endfunction

    task automatic test_directed_cases();
        send_item(ONE_Q31,      32'h8000_0000, 32'd1,         1'b0);
        send_item(32'd0,        32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        send_item(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000, 1'b1);
        // equal ratios: the earlier item stays best
        send_item(32'h4000_0000, 32'd5, 32'h0002_0000, 1'b0);
        send_item(32'h2000_0000, 32'd5, 32'h0001_0000, 1'b0);
        // zero weight never wins, and as first item gives 1.0
        send_item(32'h1000_0000, 32'd6, 32'h0001_0000, 1'b0);
        send_item(32'd0,         32'd6, 32'd0,         1'b0);
        send_item(32'd0,         32'd7, 32'd0,         1'b0);
        send_item(32'd1,         32'd7, 32'hFFFF_FFFF, 1'b1);
        // falling id mid-stream, then dropped items up to the last one
        send_item(32'h0000_0100, 32'd10, 32'h0001_0000, 1'b0);
        send_item(32'h0000_0100, 32'd9,  32'h0001_0000, 1'b0);
        send_item(32'h7FFF_FFFF, 32'd20, 32'd5,         1'b0);
        send_item(32'd0,         32'd3,  32'd1,         1'b1);
        send_item(32'h1234_5678, -32'sd5, 32'hABCD_0000, 1'b1);
        // falling id on the last item
        send_item(32'h10, 32'd1, 32'h8000, 1'b0);
        send_item(32'h20, 32'd0, 32'h8000, 1'b1);
        send_item(32'h5555_5555, 32'd0, 32'hAAAA_AAAA, 1'b0);
        send_item(32'h2AAA_AAAA, 32'd0, 32'h5555_5555, 1'b1);
    endtask

    task automatic test_random_streams(input int count);
        int     sent;
        int     len;
        int     break_at;
        bit     broken;
        longint cur;
        longint step;
        longint id_out;
        sent = 0;
        while (sent < count)
        begin
            len = $urandom_range(1, 14);
            broken = ($urandom_range(0, 9) == 0);
            break_at = $urandom_range(1, 13);
            if ($urandom_range(0, 1) == 0)
                cur = longint'($signed($urandom));
            else
                cur = longint'($urandom_range(0, 50)) - 25;
            for (int k = 0; k < len; k++)
            begin
                if (k > 0)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: step = 0;
                        5, 6, 7: step = $urandom_range(1, 3);
                        8: step = $urandom_range(1, 1 << 20);
                        default: step = $urandom;
                    endcase
                    if (cur + step <= 64'sd2147483647)
                        cur = cur + step;
                end
                id_out = cur;
                if (broken && k >= break_at)
                begin
                    id_out = cur - $urandom_range(1, 100);
                    if (id_out < -64'sd2147483648)
                        id_out = -64'sd2147483648;
                end
                if (!err_flag)
                    sent++;
                send_item(rand_p(), id_out[31:0], rand_w(), k == len - 1);
            end
        end
    endtask

    // one long cluster of heavy weights, so the weight sum runs well past 32 bits
    task automatic test_long_cluster();
        for (int k = 0; k < 40; k++)
            send_item($urandom_range(1, 32'h8000_0000), 32'd42, 32'hFFFF_FFFF, k == 39);
    endtask

    task automatic test_quiet_tail(input int count);
        calm = 1'b1;
        test_random_streams(count);
    endtask

    initial
    begin
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            result_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            if (!calm)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_clusters.size() == 0)
            begin
                $error("unexpected result: adjusted_p %0h best_index %0d status %0b",
                       result.adjusted_p, result.best_index, result.status);
                mismatches++;
            end
            else
            begin
                want = expected_clusters.pop_front();
                if (result.adjusted_p !== want.adjusted_p)
                begin
                    $error("adjusted_p: expected %0h, got %0h", want.adjusted_p,
                           result.adjusted_p);
                    mismatches++;
                end
                if (result.best_index !== want.best_index)
                begin
                    $error("best_index: expected %0d, got %0d", want.best_index,
                           result.best_index);
                    mismatches++;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %0b, got %0b", want.status, result.status);
                    mismatches++;
                end
                if (result.run_last !== want.run_last)
                begin
                    $error("run_last: expected %0b, got %0b", want.run_last, result.run_last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("weighted_cluster_min_pvalue: mismatch");
            $finish;
        end
    end

    initial
    begin
        clear_tracker();
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_streams(280);
        test_long_cluster();
        test_quiet_tail(60);
        item_valid <= 1'b0;
        while (expected_clusters.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("weighted_cluster_min_pvalue: match");
        else
            $display("weighted_cluster_min_pvalue: mismatch");
        $finish;
    end

endmodule
